/* rtl/cau_pkg.sv */
package cau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int SUM_BITS  = PROD_BITS + 2;
	localparam int DIV_STEPS = WORD_BITS;

	localparam logic [2:0] MODE_ADD   = 3'd0;
	localparam logic [2:0] MODE_SUB   = 3'd1;
	localparam logic [2:0] MODE_MUL   = 3'd2;
	localparam logic [2:0] MODE_DIV   = 3'd3;
	localparam logic [2:0] MODE_NEG   = 3'd4;
	localparam logic [2:0] MODE_CONJ  = 3'd5;
	localparam logic [2:0] MODE_MAG   = 3'd6;
	localparam logic [2:0] MODE_SQMAG = 3'd7;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_SAT = 2'd1;
	localparam logic [1:0] STAT_DZ  = 2'd2;

	localparam logic [1:0] KIND_DIRECT = 2'd0;
	localparam logic [1:0] KIND_DIV    = 2'd1;
	localparam logic [1:0] KIND_SQRT   = 2'd2;
	localparam logic [1:0] KIND_DZ     = 2'd3;

	typedef struct packed {
		logic [1:0]           kind;
		logic                 re_neg;
		logic                 im_neg;
		logic                 re_ovf;
		logic                 im_ovf;
		logic [SUM_BITS-1:0]  re_mag;
		logic [SUM_BITS-1:0]  im_mag;
		logic [PROD_BITS-1:0] den;
		logic [PROD_BITS-1:0] rem_re;
		logic [PROD_BITS-1:0] rem_im;
		logic [WORD_BITS-1:0] low_re;
		logic [WORD_BITS-1:0] low_im;
		logic [WORD_BITS-1:0] q_re;
		logic [WORD_BITS-1:0] q_im;
		logic [PROD_BITS-1:0] sq_n;
		logic [PROD_BITS-1:0] sq_res;
	} iter_t;

	// returns {saturated, word}
	function automatic logic [WORD_BITS:0] saturate(input logic neg,
		input logic [SUM_BITS-1:0] mag);
		logic [SUM_BITS-1:0] lim_n;
		logic [SUM_BITS-1:0] lim_p;
		logic [SUM_BITS-1:0] m;
		logic                s;
		lim_n = SUM_BITS'(1) << (WORD_BITS - 1);
		lim_p = lim_n - SUM_BITS'(1);
		m = mag;
		s = 1'b0;
		if (neg) begin
			if (mag > lim_n) begin
				m = lim_n;
				s = 1'b1;
			end
			m = SUM_BITS'(0) - m;
		end else if (mag > lim_p) begin
			m = lim_p;
			s = 1'b1;
		end
		return {s, m[WORD_BITS-1:0]};
	endfunction

endpackage

/* rtl/cau_in_if.sv */
interface cau_in_if import cau_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  mode;
	logic signed [WORD_BITS-1:0] a_real;
	logic signed [WORD_BITS-1:0] a_imag;
	logic signed [WORD_BITS-1:0] b_real;
	logic signed [WORD_BITS-1:0] b_imag;

	modport source (output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
	modport sink (input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

/* rtl/cau_out_if.sv */
interface cau_out_if import cau_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic signed [WORD_BITS-1:0] res_real;
	logic signed [WORD_BITS-1:0] res_imag;
	logic [1:0]                  status;

	modport source (output valid, res_real, res_imag, status, input ready);
	modport sink (input valid, res_real, res_imag, status, output ready);
endinterface

/* rtl/complex_arith_unit_core.sv */
// Throughput: one transaction per cycle; the pipeline holds as a whole while
// the result waits for ready. Stages: multiply, sum, prep, 32 radix-2
// divide / square-root steps, round and saturate into the output register.
// Reset clears the valid bits only; the data registers are not reset.
module complex_arith_unit_core import cau_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	cau_in_if.sink     operands,
	cau_out_if.source  result
);

	localparam logic [SUM_BITS-1:0] HALF =
		(FRAC_BITS > 0) ? (SUM_BITS'(1) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0)) : '0;

	logic en;
	logic valid_s36;

	assign en = !valid_s36 || result.ready;
	assign operands.ready = en;

	// stage 1: products and linear terms
	logic signed [WORD_BITS-1:0] ar, ai, br, bi, x4, x5;
	logic                        sq_mode;
	logic signed [PROD_BITS-1:0] p0_c, p1_c, p2_c, p3_c, p4_c, p5_c;
	logic signed [WORD_BITS:0]   lin_re_c, lin_im_c;

	assign ar = operands.a_real;
	assign ai = operands.a_imag;
	assign br = operands.b_real;
	assign bi = operands.b_imag;
	assign sq_mode = (operands.mode == MODE_MAG) || (operands.mode == MODE_SQMAG);
	assign x4 = sq_mode ? ar : br;
	assign x5 = sq_mode ? ai : bi;
	assign p0_c = ar * br;
	assign p1_c = ai * bi;
	assign p2_c = ar * bi;
	assign p3_c = ai * br;
	assign p4_c = x4 * x4;
	assign p5_c = x5 * x5;

	always_comb begin
		case (operands.mode)
			MODE_ADD: begin
				lin_re_c = (WORD_BITS+1)'(ar) + (WORD_BITS+1)'(br);
				lin_im_c = (WORD_BITS+1)'(ai) + (WORD_BITS+1)'(bi);
			end
			MODE_SUB: begin
				lin_re_c = (WORD_BITS+1)'(ar) - (WORD_BITS+1)'(br);
				lin_im_c = (WORD_BITS+1)'(ai) - (WORD_BITS+1)'(bi);
			end
			MODE_NEG: begin
				lin_re_c = -(WORD_BITS+1)'(ar);
				lin_im_c = -(WORD_BITS+1)'(ai);
			end
			MODE_CONJ: begin
				lin_re_c = (WORD_BITS+1)'(ar);
				lin_im_c = -(WORD_BITS+1)'(ai);
			end
			default: begin
				lin_re_c = '0;
				lin_im_c = '0;
			end
		endcase
	end

	logic                        valid_s1;
	logic [2:0]                  mode_s1;
	logic signed [PROD_BITS-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic signed [WORD_BITS:0]   lin_re_s1, lin_im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= operands.mode;
			p0_s1     <= p0_c;
			p1_s1     <= p1_c;
			p2_s1     <= p2_c;
			p3_s1     <= p3_c;
			p4_s1     <= p4_c;
			p5_s1     <= p5_c;
			lin_re_s1 <= lin_re_c;
			lin_im_s1 <= lin_im_c;
		end
	end

	// stage 2: exact sums
	logic signed [SUM_BITS-1:0] sum_re_c, sum_im_c;
	logic [PROD_BITS-1:0]       den_c;

	assign den_c = p4_s1 + p5_s1;

	always_comb begin
		case (mode_s1)
			MODE_MUL: begin
				sum_re_c = SUM_BITS'(p0_s1) - SUM_BITS'(p1_s1);
				sum_im_c = SUM_BITS'(p2_s1) + SUM_BITS'(p3_s1);
			end
			MODE_DIV: begin
				sum_re_c = SUM_BITS'(p0_s1) + SUM_BITS'(p1_s1);
				sum_im_c = SUM_BITS'(p3_s1) - SUM_BITS'(p2_s1);
			end
			MODE_MAG, MODE_SQMAG: begin
				sum_re_c = SUM_BITS'(p4_s1) + SUM_BITS'(p5_s1);
				sum_im_c = '0;
			end
			default: begin
				sum_re_c = SUM_BITS'(lin_re_s1);
				sum_im_c = SUM_BITS'(lin_im_s1);
			end
		endcase
	end

	logic                       valid_s2;
	logic [2:0]                 mode_s2;
	logic signed [SUM_BITS-1:0] sum_re_s2, sum_im_s2;
	logic [PROD_BITS-1:0]       den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2   <= mode_s1;
			sum_re_s2 <= sum_re_c;
			sum_im_s2 <= sum_im_c;
			den_s2    <= den_c;
		end
	end

	// stage 3: sign/magnitude, rounding, divider and root setup
	logic [SUM_BITS-1:0]              mag_re, mag_im;
	logic [PROD_BITS+WORD_BITS-1:0]   nw_re, nw_im;
	iter_t                            prep_c;

	assign mag_re = sum_re_s2[SUM_BITS-1] ? SUM_BITS'(-sum_re_s2) : SUM_BITS'(sum_re_s2);
	assign mag_im = sum_im_s2[SUM_BITS-1] ? SUM_BITS'(-sum_im_s2) : SUM_BITS'(sum_im_s2);
	assign nw_re = {{WORD_BITS{1'b0}}, mag_re[PROD_BITS-1:0]} << FRAC_BITS;
	assign nw_im = {{WORD_BITS{1'b0}}, mag_im[PROD_BITS-1:0]} << FRAC_BITS;

	always_comb begin
		prep_c        = '0;
		prep_c.re_neg = sum_re_s2[SUM_BITS-1];
		prep_c.im_neg = sum_im_s2[SUM_BITS-1];
		prep_c.re_mag = mag_re;
		prep_c.im_mag = mag_im;
		prep_c.den    = den_s2;
		prep_c.rem_re = nw_re[PROD_BITS+WORD_BITS-1:WORD_BITS];
		prep_c.rem_im = nw_im[PROD_BITS+WORD_BITS-1:WORD_BITS];
		prep_c.low_re = nw_re[WORD_BITS-1:0];
		prep_c.low_im = nw_im[WORD_BITS-1:0];
		prep_c.re_ovf = nw_re[PROD_BITS+WORD_BITS-1:WORD_BITS] >= den_s2;
		prep_c.im_ovf = nw_im[PROD_BITS+WORD_BITS-1:WORD_BITS] >= den_s2;
		prep_c.sq_n   = den_s2;
		case (mode_s2)
			MODE_DIV: prep_c.kind = (den_s2 == '0) ? KIND_DZ : KIND_DIV;
			MODE_MAG: prep_c.kind = KIND_SQRT;
			MODE_MUL, MODE_SQMAG: begin
				prep_c.kind   = KIND_DIRECT;
				prep_c.re_mag = (mag_re + HALF) >> FRAC_BITS;
				prep_c.im_mag = (mag_im + HALF) >> FRAC_BITS;
			end
			default: prep_c.kind = KIND_DIRECT;
		endcase
	end

	iter_t pipe_s [0:DIV_STEPS];
	logic  pipe_valid_s [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid_s[0] <= 1'b0;
		end else if (en) begin
			pipe_valid_s[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= prep_c;
		end
	end

	// one quotient bit and one root bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam logic [PROD_BITS-1:0] BITV = PROD_BITS'(1) << (2 * (DIV_STEPS - 1 - k));
		iter_t                cur;
		iter_t                nxt;
		logic [PROD_BITS:0]   r2_re, r2_im;
		logic [PROD_BITS-1:0] trial;

		assign cur   = pipe_s[k];
		assign r2_re = {cur.rem_re, cur.low_re[WORD_BITS-1]};
		assign r2_im = {cur.rem_im, cur.low_im[WORD_BITS-1]};
		assign trial = cur.sq_res + BITV;

		always_comb begin
			nxt        = cur;
			nxt.low_re = cur.low_re << 1;
			nxt.low_im = cur.low_im << 1;
			if (r2_re >= {1'b0, cur.den}) begin
				nxt.rem_re = PROD_BITS'(r2_re - {1'b0, cur.den});
				nxt.q_re   = {cur.q_re[WORD_BITS-2:0], 1'b1};
			end else begin
				nxt.rem_re = r2_re[PROD_BITS-1:0];
				nxt.q_re   = {cur.q_re[WORD_BITS-2:0], 1'b0};
			end
			if (r2_im >= {1'b0, cur.den}) begin
				nxt.rem_im = PROD_BITS'(r2_im - {1'b0, cur.den});
				nxt.q_im   = {cur.q_im[WORD_BITS-2:0], 1'b1};
			end else begin
				nxt.rem_im = r2_im[PROD_BITS-1:0];
				nxt.q_im   = {cur.q_im[WORD_BITS-2:0], 1'b0};
			end
			if (cur.sq_n >= trial) begin
				nxt.sq_n   = cur.sq_n - trial;
				nxt.sq_res = (cur.sq_res >> 1) + BITV;
			end else begin
				nxt.sq_res = cur.sq_res >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_valid_s[k+1] <= 1'b0;
			end else if (en) begin
				pipe_valid_s[k+1] <= pipe_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k+1] <= nxt;
			end
		end
	end

	// last stage: round, saturate, status
	iter_t                fin;
	logic [WORD_BITS:0]   qr_re, qr_im, sr;
	logic                 f_re_neg, f_im_neg;
	logic [SUM_BITS-1:0]  f_re_mag, f_im_mag;
	logic [WORD_BITS:0]   sat_re, sat_im;
	logic [1:0]           status_c;

	assign fin   = pipe_s[DIV_STEPS];
	assign qr_re = {1'b0, fin.q_re} +
		(WORD_BITS+1)'({fin.rem_re, 1'b0} >= {1'b0, fin.den});
	assign qr_im = {1'b0, fin.q_im} +
		(WORD_BITS+1)'({fin.rem_im, 1'b0} >= {1'b0, fin.den});
	assign sr    = fin.sq_res[WORD_BITS:0] + (WORD_BITS+1)'(fin.sq_n > fin.sq_res);

	always_comb begin
		f_re_neg = fin.re_neg;
		f_im_neg = fin.im_neg;
		f_re_mag = fin.re_mag;
		f_im_mag = fin.im_mag;
		case (fin.kind)
			KIND_DIV: begin
				f_re_mag = fin.re_ovf ? (SUM_BITS'(1) << WORD_BITS) : SUM_BITS'(qr_re);
				f_im_mag = fin.im_ovf ? (SUM_BITS'(1) << WORD_BITS) : SUM_BITS'(qr_im);
			end
			KIND_SQRT: begin
				f_re_neg = 1'b0;
				f_im_neg = 1'b0;
				f_re_mag = SUM_BITS'(sr);
				f_im_mag = '0;
			end
			KIND_DZ: begin
				f_re_neg = 1'b0;
				f_im_neg = 1'b0;
				f_re_mag = '0;
				f_im_mag = '0;
			end
			default: ;
		endcase
	end

	assign sat_re = saturate(f_re_neg, f_re_mag);
	assign sat_im = saturate(f_im_neg, f_im_mag);
	assign status_c = (fin.kind == KIND_DZ) ? STAT_DZ :
		((sat_re[WORD_BITS] || sat_im[WORD_BITS]) ? STAT_SAT : STAT_OK);

	logic [WORD_BITS-1:0] res_real_s36, res_imag_s36;
	logic [1:0]           status_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s36 <= 1'b0;
		end else if (en) begin
			valid_s36 <= pipe_valid_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_real_s36 <= sat_re[WORD_BITS-1:0];
			res_imag_s36 <= sat_im[WORD_BITS-1:0];
			status_s36   <= status_c;
		end
	end

	assign result.valid    = valid_s36;
	assign result.res_real = res_real_s36;
	assign result.res_imag = res_imag_s36;
	assign result.status   = status_s36;

endmodule
